// ===== rtl/pidaw_pkg.sv =====
// Shared types, constants and the control program of the PID controller with anti-windup.
// Depends on nothing; used by pidaw_seq, pidaw_dp and pid_antiwindup_controller_unit.
package pidaw_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_START = 3'd5;

    // Constants behind the reset values: integrator preload 230, dt 0.1, 1/dt 10.
    localparam longint INTEG_START_UNITS = 230;
    localparam longint DT_DIVISOR        = 10;
    localparam longint RATE_UNITS        = 10;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Program step numbers that are jump targets.
    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_EMIT    = 4'd9;

    typedef enum logic [2:0] {
        C_NEXT,       // fall through to the next step
        C_ALWAYS,     // jump unconditionally
        C_NO_IN,      // jump while no input beat is taken
        C_OUT_BUSY,   // jump while the output register still holds a beat
        C_NOT_UP      // jump unless the upper clamp fired
    } cond_t;

    typedef enum logic [2:0] {
        A_KP,
        A_KI,
        A_KD,
        A_T,
        A_DIFF
    } a_sel_t;

    typedef enum logic [1:0] {
        B_ERR,
        B_DT,
        B_RATE
    } b_sel_t;

    typedef enum logic [2:0] {
        W_NONE,
        W_PROP,
        W_T,
        W_SCALED,
        W_INC,
        W_DTERM
    } wb_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_ERR,
        ALU_DIFF,
        ALU_INTEG,
        ALU_SUM,
        ALU_EMIT,
        ALU_RESTORE
    } alu_t;

    typedef struct packed {
        cond_t  cond;
        step_t  target;
        logic   mul_en;
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        alu_t   alu;
    } ctrl_t;

    // Status fed back to the sequencer for its conditional jumps.
    typedef struct packed {
        logic in_fire;
        logic out_busy;
        logic clamp_up;
    } seq_flags_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               hit_upper;
        logic               hit_lower;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Control program. The multiplier result of one step is written back by
    // the next step, so products overlap with write-backs where possible.
    function automatic ctrl_t prog_word(input step_t step);
        ctrl_t w;
        w = '{cond: C_NEXT, target: STEP_IDLE, mul_en: 1'b0, a_sel: A_KP,
              b_sel: B_ERR, wb: W_NONE, alu: ALU_NONE};
        unique case (step)
            4'd0:
            begin
                w.cond   = C_NO_IN;
                w.target = STEP_IDLE;
                w.alu    = ALU_ERR;
            end
            4'd1:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_KP;
                w.b_sel  = B_ERR;
            end
            4'd2:
            begin
                w.wb     = W_PROP;
                w.mul_en = 1'b1;
                w.a_sel  = A_KI;
                w.b_sel  = B_ERR;
            end
            4'd3:
            begin
                w.wb     = W_T;
                w.mul_en = 1'b1;
                w.a_sel  = A_KD;
                w.b_sel  = B_ERR;
            end
            4'd4:
            begin
                w.wb     = W_SCALED;
                w.mul_en = 1'b1;
                w.a_sel  = A_T;
                w.b_sel  = B_DT;
            end
            4'd5:
            begin
                w.wb  = W_INC;
                w.alu = ALU_DIFF;
            end
            4'd6:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_DIFF;
                w.b_sel  = B_RATE;
                w.alu    = ALU_INTEG;
            end
            4'd7:
            begin
                w.wb = W_DTERM;
            end
            4'd8:
            begin
                w.alu = ALU_SUM;
            end
            4'd9:
            begin
                w.cond   = C_OUT_BUSY;
                w.target = STEP_EMIT;
                w.alu    = ALU_EMIT;
            end
            4'd10:
            begin
                w.cond   = C_NOT_UP;
                w.target = STEP_IDLE;
            end
            4'd11:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
                w.alu    = ALU_RESTORE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pidaw_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on pidaw_pkg.
module pidaw_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pidaw_pkg::seq_flags_t  flags,
    output pidaw_pkg::ctrl_t       ctrl
);
    import pidaw_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign ctrl = prog_word(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !flags.in_fire;
            C_OUT_BUSY: take = flags.out_busy;
            C_NOT_UP:   take = !flags.clamp_up;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
            step_next = ctrl.target;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== rtl/pidaw_dp.sv =====
// Datapath: one shared 32x32 multiplier, saturating adders and the controller state.
// Depends on pidaw_pkg; driven by control words from pidaw_seq.
module pidaw_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pidaw_pkg::ctrl_t    ctrl,
    input  logic                in_fire,
    input  logic signed [31:0]  target,
    input  logic signed [31:0]  measured,
    input  logic signed [15:0]  out_limit,
    input  logic signed [31:0]  prop_gain,
    input  logic signed [31:0]  integ_gain,
    input  logic signed [31:0]  deriv_gain,
    input  logic [30:0]         step_time,
    input  logic [30:0]         step_rate,
    input  logic                integ_load,
    input  logic signed [31:0]  integ_value,
    output pidaw_pkg::result_t  res
);
    import pidaw_pkg::*;

    localparam longint INTEG_RAW = INTEG_START_UNITS <<< FRAC_BITS;
    localparam logic signed [31:0] INTEG_RST =
        (INTEG_RAW > 64'sd2147483647) ? 32'sh7fffffff : 32'(INTEG_RAW);

    logic signed [31:0] err_reg, prop_reg, t_reg, scaled_reg, inc_reg;
    logic signed [31:0] diff_reg, dterm_reg, old_reg;
    logic signed [31:0] integ_reg, prev_reg;
    logic signed [33:0] sum_reg;
    logic signed [15:0] lim_reg;
    logic signed [63:0] prod_reg;

    logic signed [31:0] a_op, b_op, fm;
    logic signed [63:0] mul_full, sum_w, lim_q;
    logic signed [32:0] err_diff;
    logic               up, lo;

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_KP:    a_op = prop_gain;
            A_KI:    a_op = integ_gain;
            A_KD:    a_op = deriv_gain;
            A_T:     a_op = t_reg;
            A_DIFF:  a_op = diff_reg;
            default: a_op = prop_gain;
        endcase
        unique case (ctrl.b_sel)
            B_ERR:   b_op = err_reg;
            B_DT:    b_op = $signed({1'b0, step_time});
            B_RATE:  b_op = $signed({1'b0, step_rate});
            default: b_op = err_reg;
        endcase
    end

    assign mul_full = 64'(a_op) * 64'(b_op);
    // Arithmetic shift rounds toward minus infinity, then saturate.
    assign fm       = sat32(prod_reg >>> FRAC_BITS);
    assign err_diff = 33'(target) - 33'(measured);

    assign sum_w = 64'(sum_reg);
    assign lim_q = 64'(lim_reg) <<< FRAC_BITS;
    assign up    = (sum_w > lim_q) && (inc_reg > 32'sd0);
    assign lo    = (sum_reg < 34'sd0) && (inc_reg < 32'sd0);

    always_comb
    begin
        res.hit_upper = up;
        res.hit_lower = !up && lo;
        if (up)
            res.drive = sat32(lim_q);
        else if (lo)
            res.drive = 32'sd0;
        else
            res.drive = sat32(sum_w);
    end

    // Operand and product registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= mul_full;
        if (ctrl.alu == ALU_ERR && in_fire)
        begin
            err_reg <= sat32(64'(err_diff));
            lim_reg <= out_limit;
        end
        case (ctrl.wb)
            W_PROP:   prop_reg   <= fm;
            W_T:      t_reg      <= fm;
            W_SCALED: scaled_reg <= fm;
            W_INC:    inc_reg    <= fm;
            W_DTERM:  dterm_reg  <= fm;
            default:  ;
        endcase
        if (ctrl.alu == ALU_DIFF)
            diff_reg <= sat32(64'(scaled_reg) - 64'(prev_reg));
        if (ctrl.alu == ALU_INTEG)
            old_reg <= integ_reg;
        if (ctrl.alu == ALU_SUM)
            sum_reg <= 34'(prop_reg) + 34'(integ_reg) + 34'(dterm_reg);
    end

    // Controller state carried from item to item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= INTEG_RST;
            prev_reg  <= 32'sd0;
        end
        else if (integ_load)
            integ_reg <= integ_value;
        else if (ctrl.alu == ALU_INTEG)
        begin
            integ_reg <= sat32(64'(integ_reg) + 64'(inc_reg));
            prev_reg  <= scaled_reg;
        end
        else if (ctrl.alu == ALU_RESTORE)
            integ_reg <= old_reg;
    end

endmodule

// ===== rtl/pid_antiwindup_controller_unit.sv =====
// Top level of the PID controller with anti-windup: stream ports, configuration
// registers and output register. Depends on pidaw_pkg, pidaw_seq and pidaw_dp.
//
// Usage. Each beat on the s_ group carries one sample: a setpoint, a measured
// value (both signed fixed point with FRAC_BITS fraction bits) and an integer
// upper output limit. Each sample gives exactly one beat on the m_ group: the
// controller output on m_tdata and the clamp flags on m_tuser.
// Gains, dt, 1/dt and the integrator preload are written through cfg_we,
// cfg_index and cfg_data while the block is idle; writing the preload also
// loads the integrator. Indexes beyond the list are ignored.
// Timing. A small microcode program steps one shared 32x32 multiplier through
// the five products of the control law, one product per step. A new input beat
// is taken only once the program is back in its idle step, after the previous
// result has been emitted and, when the upper clamp fired, the integrator restored.
// Reset. Configuration returns to gains of zero, dt 0.1, 1/dt 10 and the
// integrator to 230; the previous scaled error is cleared; no beat is pending.
// Stalls. The result waits in an output register while m_tready is low; the
// next sample is still taken and worked on, and the program only holds at its
// emit step if the earlier result has not yet been taken.
module pid_antiwindup_controller_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [31:0] target, [63:32] measured, [79:64] out_limit
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] drive
    output logic [1:0]  m_tuser,   // [0] hit_upper, [1] hit_lower
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pidaw_pkg::*;

    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
    localparam logic [30:0] STEP_TIME_RST = 31'((ONE_Q + DT_DIVISOR / 2) / DT_DIVISOR);
    localparam logic [30:0] STEP_RATE_RST = 31'(RATE_UNITS * ONE_Q);

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [30:0]        step_time_reg, step_rate_reg;

    ctrl_t      ctrl;
    seq_flags_t flags;
    result_t    res;

    logic        in_fire, out_busy, emit, integ_load;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] drive_reg;
    logic [1:0]  flags_reg;

    // The sequencer waits for a beat only in its idle step.
    assign s_tready = (ctrl.cond == C_NO_IN);
    assign in_fire  = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign emit     = (ctrl.alu == ALU_EMIT) && !out_busy;

    always_comb
    begin
        flags.in_fire  = in_fire;
        flags.out_busy = out_busy;
        flags.clamp_up = res.hit_upper;
    end

    pidaw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign integ_load = cfg_we && (cfg_index == REG_INTEG_START);

    pidaw_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_fire     (in_fire),
        .target      ($signed(s_tdata[31:0])),
        .measured    ($signed(s_tdata[63:32])),
        .out_limit   ($signed(s_tdata[79:64])),
        .prop_gain   (prop_gain_reg),
        .integ_gain  (integ_gain_reg),
        .deriv_gain  (deriv_gain_reg),
        .step_time   (step_time_reg),
        .step_rate   (step_rate_reg),
        .integ_load  (integ_load),
        .integ_value ($signed(cfg_data)),
        .res         (res)
    );

    // Configuration registers; the preload lives only in the integrator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= 32'sd0;
            integ_gain_reg <= 32'sd0;
            deriv_gain_reg <= 32'sd0;
            step_time_reg  <= STEP_TIME_RST;
            step_rate_reg  <= STEP_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= $signed(cfg_data);
                REG_INTEG_GAIN: integ_gain_reg <= $signed(cfg_data);
                REG_DERIV_GAIN: deriv_gain_reg <= $signed(cfg_data);
                REG_STEP_TIME:  step_time_reg  <= cfg_data[30:0];
                REG_STEP_RATE:  step_rate_reg  <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // Output register: a new result loads only once the old one has gone.
    always_comb
    begin
        if (emit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            drive_reg <= res.drive;
            flags_reg <= {res.hit_lower, res.hit_upper};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = flags_reg;

`ifndef SYNTHESIS
    // After a sample is taken the program must leave its idle step.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !s_tready)
        else $error("input still accepted in the cycle after a sample was taken");

    // A new result beat only appears after the emit step loaded it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctrl.alu == ALU_EMIT))
        else $error("result beat appeared without an emit step");

    // The two clamps exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("upper and lower clamp flagged together");

    // A lower clamp always drives zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 32'd0))
        else $error("lower clamp with nonzero drive");
`endif

endmodule
